### sv/tfn_pkg.sv
// Shared types and constants of the triangle face normal unit.
`timescale 1ns / 1ps
package tfn_pkg;

  localparam int COORD_WIDTH_DEF  = 24;
  localparam int NORMAL_WIDTH_DEF = 16;

  // The command index carries a product pair, a component or a quotient bit
  // position; the bit position fits the five-bit index, so it never exceeds 31.
  localparam int CMD_IDX_W = 5;

  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;

  localparam logic [APB_ADDR_W-1:0] ADDR_PRIMITIVE_MODE = 3'd0;

  localparam logic MODE_LIST = 1'b0;
  localparam logic MODE_FAN  = 1'b1;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_ANCHOR,
    OP_PREV,
    OP_CUR,
    OP_MUL,
    OP_ACC,
    OP_ABS,
    OP_SHIFT,
    OP_ZERO,
    OP_SQ,
    OP_SACC,
    OP_INIT,
    OP_ITER,
    OP_STORE
  } dp_op_t;

  typedef struct packed {
    dp_op_t               op;
    logic [CMD_IDX_W-1:0] idx;
    logic                 upd_prev;
  } dp_cmd_t;

  typedef struct packed {
    logic zero;
    logic big;
  } dp_stat_t;

endpackage

### sv/tfn_datapath.sv
// Datapath of the triangle face normal unit: vertices, cross product, normalization.
`timescale 1ns / 1ps
module tfn_datapath #(
  parameter int COORD_WIDTH  = tfn_pkg::COORD_WIDTH_DEF,
  parameter int NORMAL_WIDTH = tfn_pkg::NORMAL_WIDTH_DEF
) (
  input  logic                           clk,
  input  tfn_pkg::dp_cmd_t               cmd,
  input  logic signed [COORD_WIDTH-1:0]  in_pos_x,
  input  logic signed [COORD_WIDTH-1:0]  in_pos_y,
  input  logic signed [COORD_WIDTH-1:0]  in_pos_z,
  output tfn_pkg::dp_stat_t              stat,
  output logic signed [NORMAL_WIDTH-1:0] norm_x,
  output logic signed [NORMAL_WIDTH-1:0] norm_y,
  output logic signed [NORMAL_WIDTH-1:0] norm_z,
  output logic                           degenerate
);

  localparam int DW   = COORD_WIDTH + 1;
  localparam int PW   = 2 * DW;
  localparam int CRW  = PW + 1;
  localparam int MW   = (DW > 32) ? DW : 32;
  localparam int MGW  = (CRW > 32) ? CRW : 32;
  localparam int FRAC = NORMAL_WIDTH - 2;
  localparam int QW   = NORMAL_WIDTH - 1;
  localparam int SW   = 64;
  localparam int AW   = 2 * FRAC + 69;

  logic signed [COORD_WIDTH-1:0] pin [3];
  logic signed [COORD_WIDTH-1:0] anc_r [3];
  logic signed [COORD_WIDTH-1:0] prv_r [3];
  logic signed [DW-1:0]          u_r [3];
  logic signed [DW-1:0]          v_r [3];
  logic signed [2*MW-1:0]        prod_r;
  logic signed [CRW-1:0]         cr_r [3];
  logic [MGW-1:0]                mag_r [3];
  logic [2:0]                    neg_r;
  logic [SW-1:0]                 s_r;
  logic signed [AW-1:0]          m_r;
  logic signed [AW-1:0]          a_r;
  logic signed [AW-1:0]          b_r;
  logic [QW-1:0]                 q_r;
  logic signed [NORMAL_WIDTH-1:0] nrm_r [3];
  logic                          degen_r;

  logic signed [MW-1:0]  opa;
  logic signed [MW-1:0]  opb;
  logic [1:0]            sel;
  logic [30:0]           sqv;
  logic signed [PW-1:0]  plo;
  logic signed [CRW-1:0] pext;
  logic signed [AW-1:0]  s_ext;
  logic [6:0]            sh_b;
  logic [6:0]            sh_s;
  logic [6:0]            sh_n;
  logic signed [AW-1:0]  a_try;
  logic signed [AW-1:0]  b_try;
  logic signed [NORMAL_WIDTH-1:0] q_pos;

  assign pin[0] = in_pos_x;
  assign pin[1] = in_pos_y;
  assign pin[2] = in_pos_z;

  assign sel   = cmd.idx[1:0];
  assign sqv   = mag_r[sel][30:0];
  assign plo   = prod_r[PW-1:0];
  assign pext  = {plo[PW-1], plo};
  assign s_ext = $signed(AW'(s_r));
  assign sh_b  = 7'(cmd.idx) + 7'd2;
  assign sh_n  = 7'(cmd.idx) + 7'd1;
  assign sh_s  = {1'b0, cmd.idx, 1'b0} + 7'd2;
  assign a_try = a_r + (b_r <<< sh_b) + (s_ext <<< sh_s);
  assign b_try = b_r + (s_ext <<< sh_n);
  assign q_pos = $signed({1'b0, q_r});

  // Operand selection of the shared multiplier.
  always_comb begin
    opa = '0;
    opb = '0;
    case (cmd.op)
      tfn_pkg::OP_MUL: begin
        case (cmd.idx)
          5'd0: begin opa = MW'(u_r[1]); opb = MW'(v_r[2]); end
          5'd1: begin opa = MW'(u_r[2]); opb = MW'(v_r[1]); end
          5'd2: begin opa = MW'(u_r[2]); opb = MW'(v_r[0]); end
          5'd3: begin opa = MW'(u_r[0]); opb = MW'(v_r[2]); end
          5'd4: begin opa = MW'(u_r[0]); opb = MW'(v_r[1]); end
          default: begin opa = MW'(u_r[1]); opb = MW'(v_r[0]); end
        endcase
      end
      tfn_pkg::OP_SQ: begin
        opa = $signed({{(MW-31){1'b0}}, sqv});
        opb = $signed({{(MW-31){1'b0}}, sqv});
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      tfn_pkg::OP_ANCHOR: begin
        for (int i = 0; i < 3; i++) anc_r[i] <= pin[i];
      end
      tfn_pkg::OP_PREV: begin
        for (int i = 0; i < 3; i++) prv_r[i] <= pin[i];
      end
      tfn_pkg::OP_CUR: begin
        for (int i = 0; i < 3; i++) begin
          u_r[i] <= DW'(prv_r[i]) - DW'(anc_r[i]);
          v_r[i] <= DW'(pin[i]) - DW'(anc_r[i]);
          if (cmd.upd_prev) prv_r[i] <= pin[i];
        end
      end
      tfn_pkg::OP_MUL, tfn_pkg::OP_SQ: begin
        prod_r <= opa * opb;
      end
      tfn_pkg::OP_ACC: begin
        if (cmd.idx[0]) cr_r[cmd.idx[2:1]] <= cr_r[cmd.idx[2:1]] - pext;
        else            cr_r[cmd.idx[2:1]] <= pext;
      end
      tfn_pkg::OP_ABS: begin
        for (int i = 0; i < 3; i++) begin
          neg_r[i] <= cr_r[i][CRW-1];
          mag_r[i] <= cr_r[i][CRW-1] ? MGW'(unsigned'(-cr_r[i]))
                                     : MGW'(unsigned'(cr_r[i]));
        end
      end
      tfn_pkg::OP_SHIFT: begin
        for (int i = 0; i < 3; i++) mag_r[i] <= mag_r[i] >> 1;
      end
      tfn_pkg::OP_ZERO: begin
        for (int i = 0; i < 3; i++) nrm_r[i] <= '0;
        degen_r <= 1'b1;
      end
      tfn_pkg::OP_SACC: begin
        s_r <= ((cmd.idx == '0) ? '0 : s_r) + SW'(prod_r[61:0]);
      end
      tfn_pkg::OP_INIT: begin
        m_r <= $signed(AW'(prod_r[61:0])) <<< (2 * FRAC + 2);
        a_r <= s_ext;
        b_r <= -s_ext;
        q_r <= '0;
      end
      tfn_pkg::OP_ITER: begin
        // Keep the candidate quotient bit when (2q-1)^2 * s stays within m^2 * 4^(F+1).
        if (a_try <= m_r) begin
          a_r <= a_try;
          b_r <= b_try;
          q_r <= q_r | (QW'(1) << cmd.idx);
        end
      end
      tfn_pkg::OP_STORE: begin
        nrm_r[sel] <= neg_r[sel] ? -q_pos : q_pos;
        degen_r    <= 1'b0;
      end
      default: begin
      end
    endcase
  end

  assign stat.zero = (mag_r[0] == '0) && (mag_r[1] == '0) && (mag_r[2] == '0);
  assign stat.big  = (|mag_r[0][MGW-1:31]) || (|mag_r[1][MGW-1:31]) ||
                     (|mag_r[2][MGW-1:31]);

  assign norm_x     = nrm_r[0];
  assign norm_y     = nrm_r[1];
  assign norm_z     = nrm_r[2];
  assign degenerate = degen_r;

endmodule

### sv/tfn_ctrl.sv
// Controller of the triangle face normal unit: vertex tracking and sequencing.
`timescale 1ns / 1ps
module tfn_ctrl #(
  parameter int NORMAL_WIDTH = tfn_pkg::NORMAL_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_mesh_start,
  input  logic               mode,
  input  logic               out_ready,
  input  tfn_pkg::dp_stat_t  stat,
  output logic               in_ready,
  output logic               out_valid,
  output logic               out_last,
  output tfn_pkg::dp_cmd_t   cmd
);

  localparam int FRAC = NORMAL_WIDTH - 2;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_ACC, S_ABS, S_SHIFT, S_SQ, S_SACC,
    S_NSQ, S_INIT, S_ITER, S_STORE, S_OUT
  } state_t;

  state_t                        state_r;
  logic [1:0]                    pos_r;
  logic [tfn_pkg::CMD_IDX_W-1:0] step_r;
  logic [1:0]                    comp_r;
  logic [1:0]                    eff_pos;
  logic                          accept;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign eff_pos   = in_mesh_start ? 2'd0 : pos_r;
  assign out_valid = (state_r == S_OUT);
  assign out_last  = out_valid && (step_r == 5'd2);

  always_comb begin
    cmd.op       = tfn_pkg::OP_IDLE;
    cmd.idx      = step_r;
    cmd.upd_prev = (mode == tfn_pkg::MODE_FAN);
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (eff_pos)
            2'd0:    cmd.op = tfn_pkg::OP_ANCHOR;
            2'd1:    cmd.op = tfn_pkg::OP_PREV;
            default: cmd.op = tfn_pkg::OP_CUR;
          endcase
        end
      end
      S_MUL:   cmd.op = tfn_pkg::OP_MUL;
      S_ACC:   cmd.op = tfn_pkg::OP_ACC;
      S_ABS:   cmd.op = tfn_pkg::OP_ABS;
      S_SHIFT: begin
        if (stat.zero)     cmd.op = tfn_pkg::OP_ZERO;
        else if (stat.big) cmd.op = tfn_pkg::OP_SHIFT;
      end
      S_SQ:    cmd.op = tfn_pkg::OP_SQ;
      S_SACC:  cmd.op = tfn_pkg::OP_SACC;
      S_NSQ: begin
        cmd.op  = tfn_pkg::OP_SQ;
        cmd.idx = 5'(comp_r);
      end
      S_INIT:  cmd.op = tfn_pkg::OP_INIT;
      S_ITER:  cmd.op = tfn_pkg::OP_ITER;
      S_STORE: begin
        cmd.op  = tfn_pkg::OP_STORE;
        cmd.idx = 5'(comp_r);
      end
      default: cmd.op = tfn_pkg::OP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pos_r   <= 2'd0;
      step_r  <= '0;
      comp_r  <= 2'd0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            case (eff_pos)
              2'd0: pos_r <= 2'd1;
              2'd1: pos_r <= 2'd2;
              default: begin
                pos_r   <= (mode == tfn_pkg::MODE_FAN) ? 2'd2 : 2'd0;
                step_r  <= '0;
                state_r <= S_MUL;
              end
            endcase
          end
        end
        S_MUL: state_r <= S_ACC;
        S_ACC: begin
          if (step_r == 5'd5) begin
            state_r <= S_ABS;
          end else begin
            step_r  <= step_r + 5'd1;
            state_r <= S_MUL;
          end
        end
        S_ABS: state_r <= S_SHIFT;
        S_SHIFT: begin
          step_r <= '0;
          if (stat.zero)      state_r <= S_OUT;
          else if (!stat.big) state_r <= S_SQ;
        end
        S_SQ: state_r <= S_SACC;
        S_SACC: begin
          if (step_r == 5'd2) begin
            comp_r  <= 2'd0;
            state_r <= S_NSQ;
          end else begin
            step_r  <= step_r + 5'd1;
            state_r <= S_SQ;
          end
        end
        S_NSQ: state_r <= S_INIT;
        S_INIT: begin
          step_r  <= 5'(FRAC);
          state_r <= S_ITER;
        end
        S_ITER: begin
          if (step_r == '0) state_r <= S_STORE;
          else              step_r  <= step_r - 5'd1;
        end
        S_STORE: begin
          if (comp_r == 2'd2) begin
            step_r  <= '0;
            state_r <= S_OUT;
          end else begin
            comp_r  <= comp_r + 2'd1;
            state_r <= S_NSQ;
          end
        end
        S_OUT: begin
          if (out_ready) begin
            if (step_r == 5'd2) state_r <= S_IDLE;
            else                step_r  <= step_r + 5'd1;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

### sv/triangle_face_normal_unit.sv
// Top level of the triangle face normal unit: configuration port, controller and datapath.
`timescale 1ns / 1ps
//
// Channel   Handshake            Payload
// input     in_valid/in_ready    in_pos_x, in_pos_y, in_pos_z, in_mesh_start
// result    out_valid/out_ready  out_norm_x, out_norm_y, out_norm_z, out_degenerate, out_last
// config    psel/penable/pready  paddr, pwrite, pwdata, prdata
//
// A vertex that does not close a triangle is stored, and the unit stays ready
// for the next vertex. A closing vertex starts the cross product; its magnitude
// is then shifted right one bit at a time until it lies below 2^31 (zero up to
// about 2 * COORD_WIDTH - 29 shifts) before the normalization.
// The datapath uses a shared multiplier and a reciprocal square root search
// that yields one quotient bit per cycle.
// A zero-area triangle skips the normalization.
// Reset (rst_n, synchronous) clears the control state and the mode register.
// The three result items of a triangle wait on out_ready; no new input item
// is taken until the last of them has been accepted.
module triangle_face_normal_unit #(
  parameter int COORD_WIDTH  = tfn_pkg::COORD_WIDTH_DEF,
  parameter int NORMAL_WIDTH = tfn_pkg::NORMAL_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [COORD_WIDTH-1:0]       in_pos_x,
  input  logic signed [COORD_WIDTH-1:0]       in_pos_y,
  input  logic signed [COORD_WIDTH-1:0]       in_pos_z,
  input  logic                                in_mesh_start,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [NORMAL_WIDTH-1:0]      out_norm_x,
  output logic signed [NORMAL_WIDTH-1:0]      out_norm_y,
  output logic signed [NORMAL_WIDTH-1:0]      out_norm_z,
  output logic                                out_degenerate,
  output logic                                out_last,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [tfn_pkg::APB_ADDR_W-1:0]      paddr,
  input  logic [tfn_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [tfn_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                pready
);

  logic              mode_r;
  logic              mode_nxt;
  logic              mode_sel;
  tfn_pkg::dp_cmd_t  cmd;
  tfn_pkg::dp_stat_t stat;

  // The port never stalls; a write lands in its access cycle.
  assign pready = 1'b1;

  // Registers sit on word addresses, so the low two address bits are ignored.
  assign mode_sel = (paddr[tfn_pkg::APB_ADDR_W-1:2] ==
                     tfn_pkg::ADDR_PRIMITIVE_MODE[tfn_pkg::APB_ADDR_W-1:2]);

  always_comb begin
    mode_nxt = mode_r;
    if (psel && penable && pwrite && pready && mode_sel) begin
      mode_nxt = pwdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= tfn_pkg::MODE_LIST;
    end else begin
      mode_r <= mode_nxt;
    end
  end

  assign prdata = mode_sel ? {{(tfn_pkg::APB_DATA_W-1){1'b0}}, mode_r} : '0;

  // The controller tracks where the vertex falls in the current triangle and
  // steps the datapath through the cross product and the normalization.
  tfn_ctrl #(
    .NORMAL_WIDTH(NORMAL_WIDTH)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_mesh_start(in_mesh_start),
    .mode         (mode_r),
    .out_ready    (out_ready),
    .stat         (stat),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_last     (out_last),
    .cmd          (cmd)
  );

  tfn_datapath #(
    .COORD_WIDTH (COORD_WIDTH),
    .NORMAL_WIDTH(NORMAL_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .cmd       (cmd),
    .in_pos_x  (in_pos_x),
    .in_pos_y  (in_pos_y),
    .in_pos_z  (in_pos_z),
    .stat      (stat),
    .norm_x    (out_norm_x),
    .norm_y    (out_norm_y),
    .norm_z    (out_norm_z),
    .degenerate(out_degenerate)
  );

`ifndef SYNTH
  // Input is never taken while results are still on offer.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input accepted while results pending");

  // A degenerate triangle always carries a zero normal.
  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_degenerate) |->
      (out_norm_x == '0 && out_norm_y == '0 && out_norm_z == '0))
    else $error("degenerate triangle with nonzero normal");

  // Once the last copy is taken, the result channel goes quiet.
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_last) |=> !out_valid)
    else $error("result offered after last copy");

  // The copy count advances only on a taken item.
  a_last_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_last)))
    else $error("copy count moved while stalled");
`endif

endmodule
